FILE: rtl/sieu_pkg.sv
// Package: payload types, command codes and widths for the scalar integer execute unit.
`default_nettype none

package sieu_pkg;

  localparam int PC_BITS  = 12;
  localparam int XLEN     = 32;
  localparam int RF_DEPTH = 32;
  localparam int RIDX_W   = $clog2(RF_DEPTH);
  localparam int CMD_W    = 6;

  localparam logic [RIDX_W-1:0] LINK_REG = RIDX_W'(31);

  // Immediate ALU forms (write rt)
  localparam logic [CMD_W-1:0] CMD_ADDI   = 6'd0;
  localparam logic [CMD_W-1:0] CMD_SLTI   = 6'd1;
  localparam logic [CMD_W-1:0] CMD_SLTIU  = 6'd2;
  localparam logic [CMD_W-1:0] CMD_ANDI   = 6'd3;
  localparam logic [CMD_W-1:0] CMD_ORI    = 6'd4;
  localparam logic [CMD_W-1:0] CMD_XORI   = 6'd5;
  localparam logic [CMD_W-1:0] CMD_LUI    = 6'd6;
  // Register-register forms and shifts (write rd)
  localparam logic [CMD_W-1:0] CMD_ADD    = 6'd7;
  localparam logic [CMD_W-1:0] CMD_SUB    = 6'd8;
  localparam logic [CMD_W-1:0] CMD_SLT    = 6'd9;
  localparam logic [CMD_W-1:0] CMD_SLTU   = 6'd10;
  localparam logic [CMD_W-1:0] CMD_AND    = 6'd11;
  localparam logic [CMD_W-1:0] CMD_OR     = 6'd12;
  localparam logic [CMD_W-1:0] CMD_XOR    = 6'd13;
  localparam logic [CMD_W-1:0] CMD_NOR    = 6'd14;
  localparam logic [CMD_W-1:0] CMD_SLL    = 6'd15;
  localparam logic [CMD_W-1:0] CMD_SRL    = 6'd16;
  localparam logic [CMD_W-1:0] CMD_SRA    = 6'd17;
  localparam logic [CMD_W-1:0] CMD_SLLV   = 6'd18;
  localparam logic [CMD_W-1:0] CMD_SRLV   = 6'd19;
  localparam logic [CMD_W-1:0] CMD_SRAV   = 6'd20;
  // Jumps
  localparam logic [CMD_W-1:0] CMD_J      = 6'd21;
  localparam logic [CMD_W-1:0] CMD_JAL    = 6'd22;
  localparam logic [CMD_W-1:0] CMD_JR     = 6'd23;
  localparam logic [CMD_W-1:0] CMD_JALR   = 6'd24;
  // Branches
  localparam logic [CMD_W-1:0] CMD_BEQ    = 6'd25;
  localparam logic [CMD_W-1:0] CMD_BNE    = 6'd26;
  localparam logic [CMD_W-1:0] CMD_BLEZ   = 6'd27;
  localparam logic [CMD_W-1:0] CMD_BGTZ   = 6'd28;
  localparam logic [CMD_W-1:0] CMD_BLTZ   = 6'd29;
  localparam logic [CMD_W-1:0] CMD_BGEZ   = 6'd30;
  localparam logic [CMD_W-1:0] CMD_BLTZAL = 6'd31;
  localparam logic [CMD_W-1:0] CMD_BGEZAL = 6'd32;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [XLEN-1:0]    instr_word;
    logic [PC_BITS-1:0] program_counter;
    logic               in_delay_slot;
    logic [PC_BITS-1:0] pending_target;
  } in_item_t;

  typedef struct packed {
    logic               write_enable;
    logic [RIDX_W-1:0]  write_index;
    logic [XLEN-1:0]    write_value;
    logic               jump_taken;
    logic [PC_BITS-1:0] jump_target;
  } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/scalar_integer_execute_unit.sv
// Top level: register file, one execute stage and an output register.
`default_nettype none

// Scalar integer execute unit. Takes one decoded instruction per transfer on
// the in_ channel and returns exactly one result per instruction on the out_
// channel, in order. Throughput is one instruction per cycle with out_ready
// held high. The transfer edge captures the instruction with its registered
// register-file reads into the execute stage; the ALU/branch result then
// loads into the output register when the execute stage advances. The
// 32 x 32 register file is a memory with
// registered reads of rs and rt, taken at the input transfer; a write from
// the instruction leaving the execute stage in that same cycle is forwarded
// into the read, so back-to-back dependent instructions see the new value.
// Reset clears a per-entry valid vector, so no clearing pass is
// needed: an entry never written reads as zero, and register 0 is never
// written. in_ready depends combinationally on out_ready: the execute stage
// holds its instruction while the output register is full and not taken.
module scalar_integer_execute_unit
  import sieu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  // ---------------------------------------------------------------------
  // Handshake and stage control
  // ---------------------------------------------------------------------
  logic            ex_v_r;       // execute stage holds an instruction
  logic            out_v_r;      // output register holds a result
  out_item_t       out_r;
  in_item_t        ex_item_r;

  logic            ex_adv;       // execute stage moves into output register
  logic            in_xfer;

  assign ex_adv   = ex_v_r && (!out_v_r || out_ready);
  assign in_ready = !ex_v_r || ex_adv;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------
  // Register file
  // ---------------------------------------------------------------------
  logic [XLEN-1:0]   rf_mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] rf_vld_r;

  out_item_t         ex_res;
  logic              rf_we;
  logic [RIDX_W-1:0] rs_idx;
  logic [RIDX_W-1:0] rt_idx;

  assign rf_we  = ex_adv && ex_res.write_enable;
  assign rs_idx = in_data.instr_word[25:21];
  assign rt_idx = in_data.instr_word[20:16];

  // Raw reads plus the terms needed to resolve them in the execute stage
  logic [XLEN-1:0] rs_raw_r, rt_raw_r, fwd_val_r;
  logic            rs_vld_r, rt_vld_r, rs_fwd_r, rt_fwd_r;

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[ex_res.write_index] <= ex_res.write_value;
    end
    if (in_xfer) begin
      rs_raw_r <= rf_mem[rs_idx];
      rt_raw_r <= rf_mem[rt_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[ex_res.write_index] <= 1'b1;
    end
  end

  // Valid bits and same-cycle forwarding, captured with the read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ex_item_r <= in_data;
      rs_vld_r  <= rf_vld_r[rs_idx];
      rt_vld_r  <= rf_vld_r[rt_idx];
      rs_fwd_r  <= rf_we && (ex_res.write_index == rs_idx);
      rt_fwd_r  <= rf_we && (ex_res.write_index == rt_idx);
      fwd_val_r <= ex_res.write_value;
    end
  end

  // ---------------------------------------------------------------------
  // Execute stage
  // ---------------------------------------------------------------------
  logic [XLEN-1:0]    rs_val, rt_val;

  always_comb begin
    rs_val = rs_fwd_r ? fwd_val_r : (rs_vld_r ? rs_raw_r : '0);
    rt_val = rt_fwd_r ? fwd_val_r : (rt_vld_r ? rt_raw_r : '0);
  end

  logic [XLEN-1:0]    w, simm, zimm, wv;
  logic [RIDX_W-1:0]  rd_i, rt_i, sa, wi;
  logic [PC_BITS-1:0] link, br_tgt, j_tgt, jr_tgt, tgt;
  logic               we, jt, cond, neg, slot;
  logic [CMD_W-1:0]   cmd;

  always_comb begin
    cmd    = ex_item_r.command;
    w      = ex_item_r.instr_word;
    slot   = ex_item_r.in_delay_slot;
    rt_i   = w[20:16];
    rd_i   = w[15:11];
    sa     = w[10:6];
    simm   = {{(XLEN-16){w[15]}}, w[15:0]};
    zimm   = {{(XLEN-16){1'b0}}, w[15:0]};
    link   = (slot ? ex_item_r.pending_target : ex_item_r.program_counter)
             + PC_BITS'(4);
    br_tgt = ex_item_r.program_counter + {w[PC_BITS-3:0], 2'b00};
    j_tgt  = {w[PC_BITS-3:0], 2'b00};
    jr_tgt = {rs_val[PC_BITS-1:2], 2'b00};
    neg    = rs_val[XLEN-1];

    we   = 1'b0;
    wi   = '0;
    wv   = '0;
    jt   = 1'b0;
    tgt  = '0;
    cond = 1'b0;

    case (cmd) inside
      [CMD_ADDI:CMD_LUI]: begin
        we = 1'b1;
        wi = rt_i;
      end
      [CMD_ADD:CMD_SRAV]: begin
        we = 1'b1;
        wi = rd_i;
      end
      CMD_JAL, CMD_BLTZAL, CMD_BGEZAL: begin
        we = 1'b1;
        wi = LINK_REG;
      end
      CMD_JALR: begin
        we = 1'b1;
        wi = rd_i;
      end
      default: ;
    endcase

    case (cmd)
      CMD_ADDI:   wv = rs_val + simm;
      CMD_SLTI:   wv = XLEN'($signed(rs_val) < $signed(simm));
      CMD_SLTIU:  wv = XLEN'(rs_val < simm);
      CMD_ANDI:   wv = rs_val & zimm;
      CMD_ORI:    wv = rs_val | zimm;
      CMD_XORI:   wv = rs_val ^ zimm;
      CMD_LUI:    wv = {w[15:0], 16'h0000};
      CMD_ADD:    wv = rs_val + rt_val;
      CMD_SUB:    wv = rs_val - rt_val;
      CMD_SLT:    wv = XLEN'($signed(rs_val) < $signed(rt_val));
      CMD_SLTU:   wv = XLEN'(rs_val < rt_val);
      CMD_AND:    wv = rs_val & rt_val;
      CMD_OR:     wv = rs_val | rt_val;
      CMD_XOR:    wv = rs_val ^ rt_val;
      CMD_NOR:    wv = ~(rs_val | rt_val);
      CMD_SLL:    wv = rt_val << sa;
      CMD_SRL:    wv = rt_val >> sa;
      CMD_SRA:    wv = XLEN'($signed(rt_val) >>> sa);
      CMD_SLLV:   wv = rt_val << rs_val[RIDX_W-1:0];
      CMD_SRLV:   wv = rt_val >> rs_val[RIDX_W-1:0];
      CMD_SRAV:   wv = XLEN'($signed(rt_val) >>> rs_val[RIDX_W-1:0]);
      CMD_JAL, CMD_JALR, CMD_BLTZAL, CMD_BGEZAL:
                  wv = {{(XLEN-PC_BITS){1'b0}}, link};
      default:    wv = '0;
    endcase

    // Jumps are dropped in a delay slot; branches are not
    case (cmd)
      CMD_J, CMD_JAL: begin
        jt  = !slot;
        tgt = j_tgt;
      end
      CMD_JR, CMD_JALR: begin
        jt  = !slot;
        tgt = jr_tgt;
      end
      CMD_BEQ:               cond = (rs_val == rt_val);
      CMD_BNE:               cond = (rs_val != rt_val);
      CMD_BLEZ:              cond = neg || (rs_val == '0);
      CMD_BGTZ:              cond = !neg && (rs_val != '0);
      CMD_BLTZ, CMD_BLTZAL:  cond = neg;
      CMD_BGEZ, CMD_BGEZAL:  cond = !neg;
      default: ;
    endcase
    if (cond) begin
      jt  = 1'b1;
      tgt = br_tgt;
    end

    // r0 is hardwired; a dropped write reports all-zero write fields
    if (wi == '0) begin
      we = 1'b0;
    end
    if (!we) begin
      wi = '0;
      wv = '0;
    end

    ex_res.write_enable = we;
    ex_res.write_index  = wi;
    ex_res.write_value  = wv;
    ex_res.jump_taken   = jt;
    ex_res.jump_target  = jt ? tgt : '0;
  end

  // ---------------------------------------------------------------------
  // Stage valids and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        ex_v_r <= 1'b1;
      end else if (ex_adv) begin
        ex_v_r <= 1'b0;
      end
      if (ex_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      out_r <= ex_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_r0_never_written: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (ex_res.write_index != '0))
    else $error("register 0 written");

  a_r0_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0])
    else $error("register 0 marked valid");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_v_r && out_v_r && !out_ready) |-> !in_ready)
    else $error("input taken while execute stage blocked");

  a_ex_drains_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ex_adv |=> out_v_r)
    else $error("execute result lost");

endmodule

`default_nettype wire

FILE: tb/sv/scalar_integer_execute_unit_test.sv
// Self-checking testbench for the scalar integer execute unit: directed and random instructions.
`default_nettype none

module scalar_integer_execute_unit_test
  import sieu_pkg::*;
;

  // Hard stop, far above the slowest legal run (about 1030 instructions,
  // worst sender gaps and the sparsest receiver pattern).
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_ITEMS    = 1000;
  localparam int PRESSURE_POINT  = 500;
  localparam int DRAIN_CYCLES    = 8;

  // Codes past the last branch are unused and must produce an all-zero result.
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_BGEZAL + 1'b1;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE    = '1;

  // Receiver back-pressure modes, picked at random by the receiver below.
  typedef enum logic [2:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_t;

  // Architectural copy of the register file plus the queue of results that
  // the block still owes, in issue order.
  class exec_result_book;
    logic [XLEN-1:0] arch_regs [RF_DEPTH];
    out_item_t       owed_results [$];
    int              errors;
    int              items_issued;
    int              results_checked;
    int              writes_seen;
    int              jumps_seen;

    function new();
      foreach (arch_regs[i]) arch_regs[i] = '0;
      errors          = 0;
      items_issued    = 0;
      results_checked = 0;
      writes_seen     = 0;
      jumps_seen      = 0;
    endfunction

    function int pending_count();
      return owed_results.size();
    endfunction

    // Executes one instruction against the architectural registers.
    function out_item_t execute_instr(in_item_t it);
      logic [RIDX_W-1:0]  rs_i, rt_i, rd_i, sa, wi;
      logic [XLEN-1:0]    w, rs_v, rt_v, simm, zimm, wv;
      logic [PC_BITS-1:0] link, tgt;
      logic               we, jt, cond, neg;
      out_item_t          r;
      w    = it.instr_word;
      rs_i = w[25:21];
      rt_i = w[20:16];
      rd_i = w[15:11];
      sa   = w[10:6];
      rs_v = arch_regs[rs_i];
      rt_v = arch_regs[rt_i];
      simm = {{16{w[15]}}, w[15:0]};
      zimm = {16'h0000, w[15:0]};
      // Link address comes from the pending target when in a delay slot.
      link = (it.in_delay_slot ? it.pending_target : it.program_counter) + PC_BITS'(4);
      we   = 1'b0;
      jt   = 1'b0;
      cond = 1'b0;
      neg  = rs_v[XLEN-1];
      wi   = '0;
      wv   = '0;
      tgt  = '0;
      if (it.command <= CMD_LUI) begin
        we = 1'b1;
        wi = rt_i;
        case (it.command)
          CMD_ADDI:  wv = rs_v + simm;
          CMD_SLTI:  wv = XLEN'($signed(rs_v) < $signed(simm));
          CMD_SLTIU: wv = XLEN'(rs_v < simm);
          CMD_ANDI:  wv = rs_v & zimm;
          CMD_ORI:   wv = rs_v | zimm;
          CMD_XORI:  wv = rs_v ^ zimm;
          default:   wv = {w[15:0], 16'h0000};
        endcase
      end else if (it.command <= CMD_SRAV) begin
        we = 1'b1;
        wi = rd_i;
        case (it.command)
          CMD_ADD:  wv = rs_v + rt_v;
          CMD_SUB:  wv = rs_v - rt_v;
          CMD_SLT:  wv = XLEN'($signed(rs_v) < $signed(rt_v));
          CMD_SLTU: wv = XLEN'(rs_v < rt_v);
          CMD_AND:  wv = rs_v & rt_v;
          CMD_OR:   wv = rs_v | rt_v;
          CMD_XOR:  wv = rs_v ^ rt_v;
          CMD_NOR:  wv = ~(rs_v | rt_v);
          CMD_SLL:  wv = rt_v << sa;
          CMD_SRL:  wv = rt_v >> sa;
          CMD_SRA:  wv = $signed(rt_v) >>> sa;
          CMD_SLLV: wv = rt_v << rs_v[4:0];
          CMD_SRLV: wv = rt_v >> rs_v[4:0];
          default:  wv = $signed(rt_v) >>> rs_v[4:0];
        endcase
      end else if (it.command <= CMD_JALR) begin
        // Jumps sitting in a delay slot are dropped, the link is not.
        if (!it.in_delay_slot) begin
          jt  = 1'b1;
          tgt = (it.command == CMD_J || it.command == CMD_JAL) ?
                {w[PC_BITS-3:0], 2'b00} : {rs_v[PC_BITS-1:2], 2'b00};
        end
        if (it.command == CMD_JAL) begin
          we = 1'b1;
          wi = LINK_REG;
          wv = XLEN'(link);
        end else if (it.command == CMD_JALR) begin
          we = 1'b1;
          wi = rd_i;
          wv = XLEN'(link);
        end
      end else if (it.command <= CMD_BGEZAL) begin
        case (it.command)
          CMD_BEQ:              cond = (rs_v == rt_v);
          CMD_BNE:              cond = (rs_v != rt_v);
          CMD_BLEZ:             cond = neg || (rs_v == '0);
          CMD_BGTZ:             cond = !neg && (rs_v != '0);
          CMD_BLTZ, CMD_BLTZAL: cond = neg;
          default:              cond = !neg;
        endcase
        // Link branches write r31 taken or not.
        if (it.command == CMD_BLTZAL || it.command == CMD_BGEZAL) begin
          we = 1'b1;
          wi = LINK_REG;
          wv = XLEN'(link);
        end
        if (cond) begin
          jt  = 1'b1;
          tgt = it.program_counter + PC_BITS'({simm[XLEN-3:0], 2'b00});
        end
      end
      if (we && wi == '0) we = 1'b0;
      if (!we) begin
        wi = '0;
        wv = '0;
      end else begin
        arch_regs[wi] = wv;
      end
      r.write_enable = we;
      r.write_index  = wi;
      r.write_value  = wv;
      r.jump_taken   = jt;
      r.jump_target  = jt ? tgt : '0;
      return r;
    endfunction

    function void note_issue(in_item_t it);
      owed_results.push_back(execute_instr(it));
      items_issued++;
    endfunction

    function void field_ok(string name, logic [XLEN-1:0] exp_v, logic [XLEN-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_retire(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      results_checked++;
      if (got.write_enable === 1'b1) writes_seen++;
      if (got.jump_taken === 1'b1) jumps_seen++;
      field_ok("write_enable", XLEN'(want.write_enable), XLEN'(got.write_enable));
      field_ok("write_index", XLEN'(want.write_index), XLEN'(got.write_index));
      field_ok("write_value", want.write_value, got.write_value);
      field_ok("jump_taken", XLEN'(want.jump_taken), XLEN'(got.jump_taken));
      field_ok("jump_target", XLEN'(want.jump_target), XLEN'(got.jump_target));
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  exec_result_book book = new();

  int       cycle_count = 0;
  int       burst_left  = 0;
  int       rx_tick     = 0;
  rx_mode_t rx_mode     = RX_ALWAYS;

  scalar_integer_execute_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results still owed", $time, book.pending_count());
    $display("Verification failed");
    $finish;
  end

  // Receiver: out_ready follows a randomly re-picked mode, so stalls land
  // on every phase of the two-stage pipe, with clean stretches too.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 63) rx_mode <= rx_mode_t'($urandom_range(0, 4));
    case (rx_mode)
      RX_ALWAYS:  out_ready <= 1'b1;
      RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RX_MOSTLY:  out_ready <= ($urandom_range(0, 9) != 0);
      RX_PATTERN: out_ready <= (rx_tick % 4 != 3);
      default:    out_ready <= (rx_tick % 8 == 0);
    endcase
  end

  // Result monitor: every out_ transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_retire(out_data);
  end

  function automatic logic [RIDX_W-1:0] pick_reg();
    int roll;
    roll = $urandom_range(0, 99);
    // Mostly a small hot set, so operands depend on recent writes.
    if (roll < 70) return RIDX_W'($urandom_range(0, 7));
    if (roll < 80) return LINK_REG;
    return RIDX_W'($urandom_range(0, RF_DEPTH - 1));
  endfunction

  function automatic logic [XLEN-1:0] enc_i(input logic [RIDX_W-1:0] rs,
                                            input logic [RIDX_W-1:0] rt,
                                            input logic [15:0] imm);
    return {6'b000000, rs, rt, imm};
  endfunction

  function automatic logic [XLEN-1:0] enc_r(input logic [RIDX_W-1:0] rs,
                                            input logic [RIDX_W-1:0] rt,
                                            input logic [RIDX_W-1:0] rd,
                                            input logic [RIDX_W-1:0] sa);
    return {6'b000000, rs, rt, rd, sa, 6'b000000};
  endfunction

  function automatic in_item_t make_instr(input logic [CMD_W-1:0] cmd,
                                          input logic [XLEN-1:0] word,
                                          input logic [PC_BITS-1:0] pc,
                                          input logic slot,
                                          input logic [PC_BITS-1:0] pend);
    in_item_t it;
    it.command         = cmd;
    it.instr_word      = word;
    it.program_counter = pc;
    it.in_delay_slot   = slot;
    it.pending_target  = pend;
    return it;
  endfunction

  function automatic in_item_t rand_instr(input logic [CMD_W-1:0] cmd);
    logic [XLEN-1:0] w;
    w        = $urandom;
    w[25:21] = pick_reg();
    w[20:16] = pick_reg();
    w[15:11] = pick_reg();
    return make_instr(cmd, w, PC_BITS'($urandom), ($urandom_range(0, 3) == 0),
                      PC_BITS'($urandom));
  endfunction

  // Sender: bursts of random length, random gaps between them. Valid stays
  // high across back-to-back transfers; payload only changes after a transfer.
  task automatic issue(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
      if (gap != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    book.note_issue(item);
  endtask

  task automatic wait_drained();
    while (book.pending_count() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t lui_it, ori_it;
    int       roll;
    int       sent;

    // Synchronous reset, released on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: operand extremes, wrap-around, register zero, delay
    // slot handling, link forms taken and not taken, an unused code.
    issue(make_instr(CMD_LUI,  enc_i(5'd0, 5'd1, 16'hFFFF), '0, 1'b0, '0));
    issue(make_instr(CMD_ORI,  enc_i(5'd1, 5'd1, 16'hFFFF), '0, 1'b0, '0));
    issue(make_instr(CMD_LUI,  enc_i(5'd0, 5'd2, 16'h8000), '1, 1'b0, '1));
    issue(make_instr(CMD_LUI,  enc_i(5'd0, 5'd3, 16'h7FFF), '0, 1'b0, '0));
    issue(make_instr(CMD_ORI,  enc_i(5'd3, 5'd3, 16'hFFFF), '0, 1'b0, '0));
    issue(make_instr(CMD_ADDI, enc_i(5'd0, 5'd4, 16'h0001), '0, 1'b0, '0));
    // Signed overflow wraps, no trap.
    issue(make_instr(CMD_ADD,  enc_r(5'd3, 5'd4, 5'd5, 5'd0), '0, 1'b0, '0));
    issue(make_instr(CMD_SUB,  enc_r(5'd0, 5'd4, 5'd6, 5'd0), '0, 1'b0, '0));
    issue(make_instr(CMD_SLT,  enc_r(5'd2, 5'd3, 5'd7, 5'd0), '0, 1'b0, '0));
    issue(make_instr(CMD_SLTU, enc_r(5'd2, 5'd3, 5'd8, 5'd0), '0, 1'b0, '0));
    issue(make_instr(CMD_SLTI, enc_i(5'd1, 5'd9, 16'h8000), '0, 1'b0, '0));
    issue(make_instr(CMD_SLTIU, enc_i(5'd4, 5'd10, 16'hFFFF), '0, 1'b0, '0));
    issue(make_instr(CMD_SRA,  enc_r(5'd0, 5'd2, 5'd11, 5'd31), '0, 1'b0, '0));
    issue(make_instr(CMD_SRAV, enc_r(5'd1, 5'd2, 5'd12, 5'd0), '0, 1'b0, '0));
    // Destination register zero: nothing written.
    issue(make_instr(CMD_ADDI, enc_i(5'd1, 5'd0, 16'h7FFF), '0, 1'b0, '0));
    // Link address wraps at the top of the PC range.
    issue(make_instr(CMD_JAL,  '1, 12'hFFC, 1'b0, '0));
    // Jump inside a delay slot: link from the pending target, no jump.
    issue(make_instr(CMD_JAL,  '1, 12'h123, 1'b1, '1));
    issue(make_instr(CMD_JR,   enc_r(5'd1, 5'd0, 5'd0, 5'd0), '0, 1'b0, '0));
    issue(make_instr(CMD_JALR, enc_r(5'd3, 5'd0, 5'd0, 5'd0), '1, 1'b0, '0));
    issue(make_instr(CMD_BEQ,  enc_i(5'd0, 5'd0, 16'h8000), '0, 1'b0, '0));
    issue(make_instr(CMD_BNE,  enc_i(5'd1, 5'd2, 16'h7FFF), '1, 1'b0, '0));
    issue(make_instr(CMD_BLEZ, enc_i(5'd2, 5'd0, 16'hFFFF), 12'h010, 1'b0, '0));
    issue(make_instr(CMD_BGTZ, enc_i(5'd3, 5'd0, 16'h0001), 12'hFFE, 1'b0, '0));
    issue(make_instr(CMD_BLTZ, enc_i(5'd0, 5'd0, 16'h0004), '0, 1'b0, '0));
    // Branch in a delay slot is still taken.
    issue(make_instr(CMD_BGEZ, enc_i(5'd0, 5'd0, 16'h0010), 12'h800, 1'b1, 12'h444));
    issue(make_instr(CMD_BLTZAL, enc_i(5'd2, 5'd0, 16'hFFF0), 12'h100, 1'b0, '0));
    // Link branch not taken still writes r31.
    issue(make_instr(CMD_BGEZAL, enc_i(5'd2, 5'd0, 16'h0020), 12'h200, 1'b1, 12'h7F0));
    issue(make_instr(CMD_LAST_CODE, '1, '1, 1'b1, '1));

    // Random part: mostly valid instructions on a hot register set, with
    // lui/ori pairs to seed full 32-bit values, plus some unused codes.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= PRESSURE_POINT && sent < PRESSURE_POINT + 2) begin
        // Drop valid first so the last transfer is not taken again.
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
        lui_it = rand_instr(CMD_LUI);
        ori_it = rand_instr(CMD_ORI);
        ori_it.instr_word[25:21] = lui_it.instr_word[20:16];
        ori_it.instr_word[20:16] = lui_it.instr_word[20:16];
        issue(lui_it);
        issue(ori_it);
        sent += 2;
      end else begin
        if (roll < 55)
          issue(rand_instr(CMD_W'($urandom_range(CMD_ADD, CMD_SRAV))));
        else if (roll < 70)
          issue(rand_instr(CMD_W'($urandom_range(CMD_ADDI, CMD_LUI))));
        else if (roll < 80)
          issue(rand_instr(CMD_W'($urandom_range(CMD_J, CMD_JALR))));
        else if (roll < 95)
          issue(rand_instr(CMD_W'($urandom_range(CMD_BEQ, CMD_BGEZAL))));
        else
          issue(rand_instr(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE))));
        sent++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Issued %0d instructions across all commands, %0d results checked.",
             book.items_issued, book.results_checked);
    $display("Saw %0d register writes and %0d scheduled jumps, %0d mismatches.",
             book.writes_seen, book.jumps_seen, book.errors);
    if (book.errors == 0 && book.pending_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
